FILE: sv/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg
// shared types, constants and helpers for the playfair digraph cipher core
// ----------------------------------------------------------------------------
package pf_pkg;

	localparam int SQ_SIDE     = 5;
	localparam int SQ_CELLS    = 25;
	localparam int NUM_LETTERS = 26;

	typedef logic [4:0] letter_t;
	typedef logic [4:0] cell_t;
	typedef logic [2:0] coord_t;

	localparam letter_t LTR_I = 5'd8;
	localparam letter_t LTR_J = 5'd9;
	localparam letter_t LTR_X = 5'd23;
	localparam letter_t LTR_Z = 5'd25;

	typedef enum logic [1:0] {
		REQ_KEY  = 2'd0,
		REQ_DONE = 2'd1,
		REQ_ENC  = 2'd2,
		REQ_DEC  = 2'd3
	} req_t;

	// placement request into the key store
	typedef struct packed {
		logic    en;
		letter_t letter;
	} place_req_t;

	// dual-address read request
	typedef struct packed {
		logic    en;
		logic [4:0] addr_a;
		logic [4:0] addr_b;
	} rd_req_t;

	// saturate above z, then fold j onto i
	function automatic letter_t norm_letter(input letter_t l);
		letter_t c;
		c = (l > LTR_Z) ? LTR_Z : l;
		return (c == LTR_J) ? LTR_I : c;
	endfunction

	// row of a cell index below 25: (c * 13) >> 6
	function automatic coord_t cell_row(input cell_t c);
		logic [8:0] p;
		p = {4'd0, c} * 9'd13;
		return p[8:6];
	endfunction

	function automatic coord_t cell_col(input cell_t c);
		coord_t r;
		cell_t  b;
		r = cell_row(c);
		b = {r, 2'b00} + {2'b00, r};
		return coord_t'(c - b);
	endfunction

	function automatic cell_t cell_index(input coord_t r, input coord_t c);
		return {r, 2'b00} + {2'b00, r} + {2'b00, c};
	endfunction

	// step one place around a row or column, forward or back
	function automatic coord_t wrap_step(input coord_t x, input logic fwd);
		coord_t res;
		if (fwd) begin
			res = (x == coord_t'(SQ_SIDE - 1)) ? 3'd0 : x + 3'd1;
		end else begin
			res = (x == 3'd0) ? coord_t'(SQ_SIDE - 1) : x - 3'd1;
		end
		return res;
	endfunction

endpackage

FILE: sv/pf_store.sv
// ----------------------------------------------------------------------------
// pf_store
// key square and letter position memories, used flags and fill pointer
// ----------------------------------------------------------------------------
module pf_store import pf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  place_req_t place,
	input  rd_req_t    pos_rd,
	output cell_t      pos_a,
	output cell_t      pos_b,
	input  rd_req_t    sq_rd,
	output letter_t    sq_a,
	output letter_t    sq_b
);

	localparam logic [NUM_LETTERS-1:0] USED_RST = NUM_LETTERS'(1) << LTR_J;

	letter_t ksq_mem [SQ_CELLS];
	cell_t   pos_mem [NUM_LETTERS];

	logic [NUM_LETTERS-1:0] used_q;
	cell_t                  fill_q;
	cell_t                  pos_a_q, pos_b_q;
	letter_t                sq_a_q, sq_b_q;
	logic                   place_ok;

	assign place_ok = place.en && (fill_q < cell_t'(SQ_CELLS)) && !used_q[place.letter];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= USED_RST;
			fill_q <= '0;
		end else if (place_ok) begin
			used_q[place.letter] <= 1'b1;
			fill_q               <= fill_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (place_ok) begin
			ksq_mem[fill_q]       <= place.letter;
			pos_mem[place.letter] <= fill_q;
		end
		if (pos_rd.en) begin
			pos_a_q <= pos_mem[pos_rd.addr_a];
			pos_b_q <= pos_mem[pos_rd.addr_b];
		end
		if (sq_rd.en) begin
			sq_a_q <= ksq_mem[sq_rd.addr_a];
			sq_b_q <= ksq_mem[sq_rd.addr_b];
		end
	end

	assign pos_a = pos_a_q;
	assign pos_b = pos_b_q;
	assign sq_a  = sq_a_q;
	assign sq_b  = sq_b_q;

endmodule

FILE: sv/pf_rule.sv
// ----------------------------------------------------------------------------
// pf_rule
// playfair row / column / rectangle rule on two cell positions
// ----------------------------------------------------------------------------
module pf_rule import pf_pkg::*; (
	input  cell_t cell_a,
	input  cell_t cell_b,
	input  logic  enc,
	output cell_t new_a,
	output cell_t new_b
);

	coord_t r1, c1, r2, c2;
	coord_t nr1, nc1, nr2, nc2;

	always_comb begin
		r1 = cell_row(cell_a);
		c1 = cell_col(cell_a);
		r2 = cell_row(cell_b);
		c2 = cell_col(cell_b);
		nr1 = r1;
		nc1 = c1;
		nr2 = r2;
		nc2 = c2;
		if (r1 == r2) begin
			nc1 = wrap_step(c1, enc);
			nc2 = wrap_step(c2, enc);
		end else if (c1 == c2) begin
			nr1 = wrap_step(r1, enc);
			nr2 = wrap_step(r2, enc);
		end else begin
			// rectangle: swap columns
			nc1 = c2;
			nc2 = c1;
		end
		new_a = cell_index(nr1, nc1);
		new_b = cell_index(nr2, nc2);
	end

endmodule

FILE: sv/playfair_digraph_cipher_core.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_core
// 5x5 playfair key square builder with pair encrypt and decrypt
// ----------------------------------------------------------------------------
// usage:
//   a request is taken at a clock edge with start high and busy low; req_type
//   picks key letter, key complete, encrypt pair or decrypt pair
//   every request gives exactly one result, shown for one cycle with done high;
//   the receiver cannot stall, so done is never held
// steps (request to done):
//   key letter: one pass through the placement unit
//   key complete: the placement unit walks the 26 letters a..z,
//     one letter per cycle, filling every free cell
//   pair: two registered memory reads in a row (letter position map, then
//     key square), then the registered result
//   requests that need no work (pair before ready, key items after ready)
//     give their result in the cycle after the request
//   busy stays high from the request until the result cycle (it stays low
//   for requests that need no work); one request is in flight at a time
// reset:
//   clears the used-letter flags (j stays marked), the fill pointer and the
//   ready flag; the square memories are not cleared, cells are only read after
//   every cell has been written
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_core import pf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] req_type,
	input  logic [4:0] letter_first,
	input  logic [4:0] letter_second,
	output logic       done,
	output logic [4:0] out_first,
	output logic [4:0] out_second,
	output logic       status
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PLACE = 5'b00010,
		ST_FILL  = 5'b00100,
		ST_CELL  = 5'b01000,
		ST_RES   = 5'b10000
	} state_t;

	state_t  state_q;
	logic    ready_q;
	letter_t cnt_q;       // alphabet walk during key fill
	letter_t key_ltr_q;   // pending key letter
	logic    enc_q;
	logic    done_q;
	logic    status_q;
	letter_t out_a_q, out_b_q;

	logic       accept;
	req_t       req;
	letter_t    a_in, b_in;
	logic       is_pair;
	place_req_t place;
	rd_req_t    pos_rd, sq_rd;
	cell_t      pos_a, pos_b, new_a, new_b;
	letter_t    sq_a, sq_b;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign req     = req_t'(req_type);
	assign is_pair = (req == REQ_ENC) || (req == REQ_DEC);

	// normalize letters; doubled letter on encrypt gets x as second
	always_comb begin
		a_in = norm_letter(letter_first);
		b_in = norm_letter(letter_second);
		if (req == REQ_ENC && a_in == b_in) begin
			b_in = LTR_X;
		end
	end

	// placement unit: shared by single key letters and the fill walk
	always_comb begin
		place.en     = (state_q == ST_PLACE) || (state_q == ST_FILL);
		place.letter = (state_q == ST_FILL) ? cnt_q : key_ltr_q;
	end

	// first read: where each pair letter sits in the square
	assign pos_rd.en     = accept && ready_q && is_pair;
	assign pos_rd.addr_a = a_in;
	assign pos_rd.addr_b = b_in;

	// second read: the letters at the moved cells
	assign sq_rd.en     = (state_q == ST_CELL);
	assign sq_rd.addr_a = new_a;
	assign sq_rd.addr_b = new_b;

	pf_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.place  (place),
		.pos_rd (pos_rd),
		.pos_a  (pos_a),
		.pos_b  (pos_b),
		.sq_rd  (sq_rd),
		.sq_a   (sq_a),
		.sq_b   (sq_b)
	);

	pf_rule u_rule (
		.cell_a (pos_a),
		.cell_b (pos_b),
		.enc    (enc_q),
		.new_a  (new_a),
		.new_b  (new_b)
	);

	// sequencer and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req)
							REQ_KEY: begin
								if (ready_q) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_PLACE;
								end
							end
							REQ_DONE: begin
								if (ready_q) begin
									done_q <= 1'b1;
								end else begin
									cnt_q   <= '0;
									state_q <= ST_FILL;
								end
							end
							default: begin
								if (ready_q) begin
									state_q <= ST_CELL;
								end else begin
									done_q <= 1'b1;
								end
							end
						endcase
					end
				end
				ST_PLACE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_FILL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == letter_t'(NUM_LETTERS - 1)) begin
						ready_q <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_CELL: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			key_ltr_q <= a_in;
			enc_q     <= (req == REQ_ENC);
			out_a_q   <= '0;
			out_b_q   <= '0;
			status_q  <= is_pair && !ready_q;
		end
		if (state_q == ST_RES) begin
			out_a_q <= sq_a;
			out_b_q <= sq_b;
		end
	end

	assign done       = done_q;
	assign out_first  = out_a_q;
	assign out_second = out_b_q;
	assign status     = status_q;

endmodule
